### rtl/mcft_pkg.sv
// Shared types and constants of the M1 closure flux tensor core.
package mcft_pkg;

    localparam int DIMS      = 3;
    localparam int DIMS_USED = (DIMS < 1) ? 1 : ((DIMS > 3) ? 3 : DIMS);
    localparam logic [1:0] LAST_ROW = 2'(DIMS_USED - 1);

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int QDEPTH = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_SPEED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_DENSITY = 1'b1;

    typedef struct packed {
        logic signed [31:0] photon_density;
        logic signed [31:0] flux_x;
        logic signed [31:0] flux_y;
        logic signed [31:0] flux_z;
    } in_t;

    typedef struct packed {
        logic [1:0]         row_dim;
        logic signed [31:0] flux_along;
        logic signed [31:0] pressure_x;
        logic signed [31:0] pressure_y;
        logic signed [31:0] pressure_z;
        logic               last_row;
    } out_t;

    typedef struct packed {
        logic [30:0]      dens;
        logic             iso;
        logic [2:0][31:0] flux;
        logic [2:0][31:0] mag;
    } cell_t;

    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

endpackage

### rtl/mcft_div.sv
// Iterative fractional divider: floor(a * 2^30 / b), 1.0 if a >= b, one quotient bit per cycle.
module mcft_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [30:0] q
);
    import mcft_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        one_reg, one_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] b_reg, b_next;
    logic [29:0] q_reg, q_next;
    logic [63:0] rem2;
    logic        ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        one_next  = one_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        rem2      = {rem_reg[62:0], 1'b0};
        ge        = (rem2 >= b_reg);
        if (start)
        begin
            b_next   = b;
            rem_next = a;
            q_next   = '0;
            cnt_next = '0;
            if (a >= b)
            begin
                one_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                one_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem2 - b_reg) : rem2;
            q_next   = {q_reg[28:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        one_reg <= one_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = one_reg ? ONE_Q30 : {1'b0, q_reg};
endmodule

### rtl/mcft_isqrt.sv
// Iterative 64-bit integer square root, two radicand bits per cycle.
module mcft_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] v,
    output logic        done,
    output logic [32:0] res
);
    import mcft_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] sum;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        sum       = res_reg + bit_reg;
        if (start)
        begin
            v_next    = v;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= sum)
            begin
                v_next   = v_reg - sum;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign res  = res_reg[32:0];
endmodule

### rtl/mcft_front.sv
// Front end: density floor, branch classification, dimension masking, magnitudes.
module mcft_front (
    input  mcft_pkg::in_t   voxel,
    input  logic [30:0]     small_density,
    output mcft_pkg::cell_t entry
);
    import mcft_pkg::*;

    logic [2:0][31:0] raw;
    logic [30:0]      dens;

    always_comb
    begin
        raw[0] = voxel.flux_x;
        raw[1] = voxel.flux_y;
        raw[2] = voxel.flux_z;
        dens   = voxel.photon_density[31] ? small_density : voxel.photon_density[30:0];
        entry.dens = dens;
        entry.iso  = !(dens > small_density);
        for (int d = 0; d < 3; d++)
        begin
            if (d < DIMS_USED)
            begin
                entry.flux[d] = raw[d];
                entry.mag[d]  = raw[d][31] ? (32'd0 - raw[d]) : raw[d];
            end
            else
            begin
                entry.flux[d] = '0;
                entry.mag[d]  = '0;
            end
        end
    end
endmodule

### rtl/mcft_queue.sv
// Two-entry cell queue between front and back end.
module mcft_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mcft_pkg::cell_t  wdata,
    input  logic             pop,
    output mcft_pkg::cell_t  rdata,
    output mcft_pkg::qstat_t stat
);
    import mcft_pkg::*;

    cell_t      mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'(QDEPTH));
    assign stat.valid = (count_reg != 2'd0);
endmodule

### rtl/mcft_back.sv
// Back end: closure sequencer, shared divider and square root, row output.
module mcft_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mcft_pkg::cell_t  head,
    input  mcft_pkg::qstat_t stat,
    input  logic [30:0]      light_speed,
    output logic             pop,
    output logic             done,
    output mcft_pkg::out_t   row
);
    import mcft_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_SQ   = 5'd1,  S_CN   = 5'd2,  S_C2   = 5'd3,
                           S_C2B  = 5'd4,  S_BR   = 5'd5,  S_SQW  = 5'd6,  S_RFW  = 5'd7,
                           S_F2   = 5'd8,  S_S    = 5'd9,  S_SW   = 5'd10, S_CHI  = 5'd11,
                           S_CHIW = 5'd12, S_TERM = 5'd13, S_U    = 5'd14, S_UW   = 5'd15,
                           S_UU   = 5'd16, S_T    = 5'd17, S_P1   = 5'd18, S_P2   = 5'd19,
                           S_EMIT = 5'd20, S_DIV3 = 5'd21, S_ISO  = 5'd22;

    logic [4:0]       state_reg, state_next;
    logic             done_reg, done_next;
    cell_t            cell_reg, cell_next;
    logic [1:0]       idx_reg, idx_next;
    logic [1:0]       row_idx_reg, row_idx_next;
    logic [63:0]      fsq_reg, fsq_next;
    logic [32:0]      fmag_reg, fmag_next;
    logic [61:0]      cn_reg, cn_next;
    logic [63:0]      ph_reg, ph_next;
    logic [63:0]      pl_reg, pl_next;
    logic [61:0]      m_reg, m_next;
    logic [30:0]      rf_reg, rf_next;
    logic [30:0]      f2_reg, f2_next;
    logic [32:0]      s_reg, s_next;
    logic [30:0]      chi_reg, chi_next;
    logic [29:0]      iterm_reg, iterm_next;
    logic             ot_neg_reg, ot_neg_next;
    logic [30:0]      ot_mag_reg, ot_mag_next;
    logic [2:0]       u_neg_reg, u_neg_next;
    logic [2:0][30:0] u_mag_reg, u_mag_next;
    logic             uu_neg_reg, uu_neg_next;
    logic [30:0]      uu_mag_reg, uu_mag_next;
    logic signed [32:0] t_reg, t_next;
    logic             t_neg_reg, t_neg_next;
    logic [63:0]      pa_reg, pa_next;
    logic [63:0]      pb_reg, pb_next;
    logic [2:0][31:0] prow_reg, prow_next;
    logic [31:0]      q3_reg, q3_next;
    out_t             row_reg, row_next;

    logic        div_start, div_done;
    logic [63:0] div_a, div_b;
    logic [30:0] div_q;
    logic        sq_start, sq_done;
    logic [63:0] sq_v;
    logic [32:0] sq_res;

    logic [63:0] sq_prod;
    logic [61:0] uu_prod;
    logic [61:0] t_prod;
    logic [30:0] t_mag;
    logic signed [32:0] t_sgn;
    logic [31:0] chi3;
    logic [32:0] sq_arg;
    logic [31:0] pmag;
    logic [63:0] psum;
    logic [31:0] psat;
    logic [16:0] d3_hi;
    logic [18:0] d3_x;
    logic [31:0] d3_q;
    logic [31:0] diag;

    mcft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    mcft_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (sq_v),
        .done  (sq_done),
        .res   (sq_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cell_next    = cell_reg;
        idx_next     = idx_reg;
        row_idx_next = row_idx_reg;
        fsq_next     = fsq_reg;
        fmag_next    = fmag_reg;
        cn_next      = cn_reg;
        ph_next      = ph_reg;
        pl_next      = pl_reg;
        m_next       = m_reg;
        rf_next      = rf_reg;
        f2_next      = f2_reg;
        s_next       = s_reg;
        chi_next     = chi_reg;
        iterm_next   = iterm_reg;
        ot_neg_next  = ot_neg_reg;
        ot_mag_next  = ot_mag_reg;
        u_neg_next   = u_neg_reg;
        u_mag_next   = u_mag_reg;
        uu_neg_next  = uu_neg_reg;
        uu_mag_next  = uu_mag_reg;
        t_next       = t_reg;
        t_neg_next   = t_neg_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        prow_next    = prow_reg;
        q3_next      = q3_reg;
        row_next     = row_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        div_a        = '0;
        div_b        = '0;
        sq_start     = 1'b0;
        sq_v         = fsq_reg;

        sq_prod = 64'(cell_reg.mag[idx_reg]) * 64'(cell_reg.mag[idx_reg]);
        uu_prod = 62'(u_mag_reg[idx_reg]) * 62'(u_mag_reg[row_idx_reg]);
        t_prod  = 62'(ot_mag_reg) * 62'(uu_mag_reg);
        t_mag   = 31'(t_prod >> 30);
        t_sgn   = (ot_neg_reg ^ uu_neg_reg) ? (33'sd0 - $signed({2'b0, t_mag}))
                                            : $signed({2'b0, t_mag});
        chi3    = {1'b0, chi_reg} + {chi_reg, 1'b0};
        sq_arg  = 33'h1_0000_0000 - (33'(f2_reg) * 33'd3);
        pmag    = t_reg[32] ? 32'(33'sd0 - t_reg) : 32'(t_reg);
        psum    = pa_reg + (pb_reg >> 30);
        if (t_neg_reg)
        begin
            psat = (psum >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - psum[31:0]);
        end
        else
        begin
            psat = (psum >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : psum[31:0];
        end
        // m / 3 with 2^16 = 3 * 21845 + 1; only used below 3 * 2^31
        d3_hi = m_reg[32:16];
        d3_x  = 19'(d3_hi) + 19'(m_reg[15:0]);
        d3_q  = 32'((38'(d3_x) * 38'd174763) >> 19);
        diag  = q3_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (stat.valid)
                begin
                    pop          = 1'b1;
                    cell_next    = head;
                    fsq_next     = '0;
                    idx_next     = '0;
                    row_idx_next = '0;
                    state_next   = S_SQ;
                end
            end
            S_SQ:
            begin
                fsq_next = fsq_reg + sq_prod;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = S_CN;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_CN:
            begin
                cn_next    = 62'(light_speed) * 62'(cell_reg.dens);
                sq_start   = !cell_reg.iso;
                state_next = S_C2;
            end
            S_C2:
            begin
                ph_next    = 64'(light_speed) * 64'(cn_reg[61:32]);
                pl_next    = 64'(light_speed) * 64'(cn_reg[31:0]);
                state_next = S_C2B;
            end
            S_C2B:
            begin
                m_next     = 62'(ph_reg + (pl_reg >> 32));
                state_next = S_BR;
            end
            S_BR:
            begin
                if (cell_reg.iso)
                begin
                    state_next = S_DIV3;
                end
                else
                begin
                    state_next = S_SQW;
                end
            end
            S_SQW:
            begin
                if (sq_done)
                begin
                    fmag_next = sq_res;
                    if (sq_res == 33'd0)
                    begin
                        rf_next    = '0;
                        state_next = S_F2;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = 64'({sq_res, 16'b0});
                        div_b      = 64'(cn_reg);
                        state_next = S_RFW;
                    end
                end
            end
            S_RFW:
            begin
                if (div_done)
                begin
                    rf_next    = div_q;
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                f2_next    = 31'((62'(rf_reg) * 62'(rf_reg)) >> 30);
                state_next = S_S;
            end
            S_S:
            begin
                sq_start   = 1'b1;
                sq_v       = 64'({sq_arg, 30'b0});
                state_next = S_SW;
            end
            S_SW:
            begin
                if (sq_done)
                begin
                    s_next     = sq_res;
                    state_next = S_CHI;
                end
            end
            S_CHI:
            begin
                div_start  = 1'b1;
                div_a      = 64'(34'(ONE_Q30) * 34'd3 + (34'(f2_reg) << 2));
                div_b      = 64'(35'(ONE_Q30) * 35'd5 + (35'(s_reg) << 1));
                state_next = S_CHIW;
            end
            S_CHIW:
            begin
                if (div_done)
                begin
                    chi_next   = div_q;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                iterm_next = 30'((ONE_Q30 - chi_reg) >> 1);
                if (chi3 >= 32'(ONE_Q30))
                begin
                    ot_neg_next = 1'b0;
                    ot_mag_next = 31'((chi3 - 32'(ONE_Q30)) >> 1);
                end
                else
                begin
                    ot_neg_next = 1'b1;
                    ot_mag_next = 31'((32'(ONE_Q30) - chi3) >> 1);
                end
                idx_next   = '0;
                state_next = S_U;
            end
            S_U:
            begin
                u_neg_next[idx_reg] = cell_reg.flux[idx_reg][31];
                if (fmag_reg == 33'd0)
                begin
                    u_mag_next[idx_reg] = '0;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = '0;
                        state_next = S_UU;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = 64'(cell_reg.mag[idx_reg]);
                    div_b      = 64'(fmag_reg);
                    state_next = S_UW;
                end
            end
            S_UW:
            begin
                if (div_done)
                begin
                    u_mag_next[idx_reg] = div_q;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = '0;
                        state_next = S_UU;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_U;
                    end
                end
            end
            S_UU:
            begin
                uu_neg_next = u_neg_reg[idx_reg] ^ u_neg_reg[row_idx_reg];
                uu_mag_next = 31'(uu_prod >> 30);
                state_next  = S_T;
            end
            S_T:
            begin
                t_next     = t_sgn + ((idx_reg == row_idx_reg) ? $signed({3'b0, iterm_reg})
                                                               : 33'sd0);
                state_next = S_P1;
            end
            S_P1:
            begin
                t_neg_next = t_reg[32];
                pa_next    = 64'(pmag) * 64'(m_reg[61:30]);
                pb_next    = 64'(pmag) * 64'(m_reg[29:0]);
                state_next = S_P2;
            end
            S_P2:
            begin
                prow_next[idx_reg] = (32'(idx_reg) < 32'(DIMS_USED)) ? psat : 32'd0;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_UU;
                end
            end
            S_DIV3:
            begin
                q3_next    = (m_reg >= 62'h1_8000_0000) ? 32'h7FFF_FFFF
                                                        : (32'(d3_hi) * 32'd21845 + d3_q);
                state_next = S_ISO;
            end
            S_ISO:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prow_next[k] = ((k < DIMS_USED) && (2'(k) == row_idx_reg)) ? diag : 32'd0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                done_next           = 1'b1;
                row_next.row_dim    = row_idx_reg;
                row_next.flux_along = cell_reg.iso ? 32'sd0 : cell_reg.flux[row_idx_reg];
                row_next.pressure_x = prow_reg[0];
                row_next.pressure_y = prow_reg[1];
                row_next.pressure_z = prow_reg[2];
                row_next.last_row   = (row_idx_reg == LAST_ROW);
                idx_next            = '0;
                if (row_idx_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    row_idx_next = row_idx_reg + 2'd1;
                    state_next   = cell_reg.iso ? S_ISO : S_UU;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg    <= cell_next;
        idx_reg     <= idx_next;
        row_idx_reg <= row_idx_next;
        fsq_reg     <= fsq_next;
        fmag_reg    <= fmag_next;
        cn_reg      <= cn_next;
        ph_reg      <= ph_next;
        pl_reg      <= pl_next;
        m_reg       <= m_next;
        rf_reg      <= rf_next;
        f2_reg      <= f2_next;
        s_reg       <= s_next;
        chi_reg     <= chi_next;
        iterm_reg   <= iterm_next;
        ot_neg_reg  <= ot_neg_next;
        ot_mag_reg  <= ot_mag_next;
        u_neg_reg   <= u_neg_next;
        u_mag_reg   <= u_mag_next;
        uu_neg_reg  <= uu_neg_next;
        uu_mag_reg  <= uu_mag_next;
        t_reg       <= t_next;
        t_neg_reg   <= t_neg_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        prow_reg    <= prow_next;
        q3_reg      <= q3_next;
        row_reg     <= row_next;
    end

    assign done = done_reg;
    assign row  = row_reg;
endmodule

### rtl/m1_closure_flux_tensor_core.sv
// Top level of the M1 closure flux tensor core.
// Usage:
//   Input: drive one cell beat on voxel and raise start; the beat is taken at a
//   rising edge with start high and busy low. busy rises while the two-entry
//   cell queue is full.
//   Output: each tensor row appears on row for one cycle with done high; rows
//   come in order 0..DIMS_USED-1, last_row marks the final one of a cell. The
//   receiver cannot stall, and nothing here waits on it.
//   Config: cfg_we with cfg_index 0 (light speed) or 1 (density floor) and
//   cfg_data writes a register at once; write only while idle.
// Sequence:
//   A closure cell goes through the back end as: a 32-step square root
//   twice and up to five 30-step quotients (reduced flux, Eddington factor
//   and three direction components) through one shared divider, then the
//   UU, T, P1 and P2 steps per tensor entry and an emit step per row. An
//   isotropic cell takes setup, the divide by three, then an ISO and an emit
//   step per row. The queue lets up to two cells wait.
// Reset: clears the queue and the sequencer; light speed returns to 1.0 and
//   the floor to one LSB.
module m1_closure_flux_tensor_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mcft_pkg::in_t                      voxel,
    input  logic                               cfg_we,
    input  logic [mcft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [30:0]                        cfg_data,
    output logic                               done,
    output mcft_pkg::out_t                     row
);
    import mcft_pkg::*;

    logic [30:0] light_speed_reg, light_speed_next;
    logic [30:0] small_density_reg, small_density_next;
    cell_t       entry;
    cell_t       head;
    qstat_t      stat;
    logic        push;
    logic        pop;

    always_comb
    begin
        light_speed_next   = light_speed_reg;
        small_density_next = small_density_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LIGHT_SPEED:   light_speed_next   = cfg_data;
                REG_SMALL_DENSITY: small_density_next = cfg_data;
                default:           light_speed_next   = light_speed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_speed_reg   <= 31'd65536;
            small_density_reg <= 31'd1;
        end
        else
        begin
            light_speed_reg   <= light_speed_next;
            small_density_reg <= small_density_next;
        end
    end

    assign busy = stat.full;
    assign push = start && !stat.full;

    mcft_front u_front (
        .voxel         (voxel),
        .small_density (small_density_reg),
        .entry         (entry)
    );

    mcft_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .stat  (stat)
    );

    mcft_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (stat),
        .light_speed (light_speed_reg),
        .pop         (pop),
        .done        (done),
        .row         (row)
    );
endmodule
